FILE: rtl/core/mste_pkg.sv
package mste_pkg;

  localparam int NUM_SLOTS = 10;
  localparam int COORD_FRAC_BITS = 8;
  localparam int SLOT_W = 4;
  localparam int COUNT_W = 4;
  localparam int COORD_W = 24;
  localparam int STAMP_W = 48;
  localparam int PROD_W = 32 + 16 + COORD_FRAC_BITS;
  localparam int CAL_W = 17;

  localparam logic [15:0] TYPE_SYN = 16'd0;
  localparam logic [15:0] TYPE_ABS = 16'd3;
  localparam logic [15:0] CODE_SLOT = 16'h002f;
  localparam logic [15:0] CODE_TRACK = 16'h0039;
  localparam logic [15:0] CODE_POS_X = 16'h0035;
  localparam logic [15:0] CODE_POS_Y = 16'h0036;
  localparam logic [31:0] ID_ENDED = 32'hffff_ffff;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};

  localparam logic [2:0] REG_MAX_SLOTS = 3'd0;
  localparam logic [2:0] REG_RES_X = 3'd1;
  localparam logic [2:0] REG_RES_Y = 3'd2;
  localparam logic [2:0] REG_CAL_W = 3'd3;
  localparam logic [2:0] REG_CAL_H = 3'd4;

  typedef enum logic [2:0] {
    ACT_DOWN = 3'd0,
    ACT_MOVE = 3'd1,
    ACT_UP = 3'd2,
    ACT_PDOWN = 3'd3,
    ACT_PUP = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_DIV,
    ST_SCAN,
    ST_EMIT,
    ST_WAIT
  } state_t;

endpackage

FILE: rtl/core/multitouch_slot_event_tracker_core.sv
// Multitouch slot event tracker (protocol B slot mode).
// Input channel: ev_type, ev_code, ev_value, stamp_us with in_valid/in_ready.
// Output channel: one pointer record per active slot on a sync report (an empty
// record if none), out_valid/out_ready; last marks the final record of a report.
// Configuration: cfg_we/cfg_index/cfg_data, write only, while idle.
// Timing: slot, tracking-id and other non-position events are accepted back
// to back. A non-negative position event runs a bit-serial restoring divide
// on one shared subtract/compare unit: after the accept, ST_MULT multiplies
// the value by the resolution, then ST_DIV shifts in the quotient bit by bit;
// no new event is taken until the divide ends.
// A sync report walks the slots one per cycle, first to count active slots
// and turn repeated downs into moves, then, while the output is free, to emit
// records up to the last active one, then snapshots the slots in ST_WAIT.
// in_ready is high only while the sequencer is idle. A stalled receiver
// holds the current record in the output register and the slot walk waits.
// Reset clears the slot table, counters and configuration to their defaults;
// the block is ready as soon as reset is released.
module multitouch_slot_event_tracker_core
  import mste_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        ev_type,
  input  logic [15:0]        ev_code,
  input  logic signed [31:0] ev_value,
  input  logic [47:0]        stamp_us,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         slot_index,
  output logic signed [31:0] tracking_id,
  output logic [2:0]         pointer_action,
  output logic [23:0]        pos_x,
  output logic [23:0]        pos_y,
  output logic               pointer_valid,
  output logic               last,
  output logic [2:0]         gesture_action,
  output logic [47:0]        down_time_us,
  output logic [47:0]        event_time_us,
  output logic [3:0]         pointer_count,
  output logic               sequence_error
);

  logic [3:0]         max_slots;
  logic [15:0]        resolution_x, resolution_y;
  logic [CAL_W-1:0]   calibrated_width, calibrated_height;

  logic [31:0]        slot_id [NUM_SLOTS];
  action_t            slot_action [NUM_SLOTS];
  logic [COORD_W-1:0] slot_x [NUM_SLOTS];
  logic [COORD_W-1:0] slot_y [NUM_SLOTS];
  logic               prev_id_nonzero [NUM_SLOTS];
  action_t            prev_action [NUM_SLOTS];
  logic [COUNT_W-1:0] touch_count;
  logic [SLOT_W-1:0]  current_slot;
  action_t            overall_action;
  logic [STAMP_W-1:0] first_touch_time, latest_time;

  state_t state, state_next;

  // divider
  logic [PROD_W-1:0]  rem_q;       // dividend shifted out, quotient shifted in
  logic [CAL_W:0]     rem_r;       // partial remainder
  logic [CAL_W-1:0]   divisor;
  logic [5:0]         bit_cnt;
  logic               div_is_y;
  logic [31:0]        raw_val;
  logic [15:0]        mul_res;
  logic [SLOT_W-1:0]  div_slot;

  logic [SLOT_W-1:0]  walk;
  logic [COUNT_W-1:0] total, emitted;

  logic [SLOT_W-1:0]  eff_slots;
  assign eff_slots = (max_slots > SLOT_W'(NUM_SLOTS)) ? SLOT_W'(NUM_SLOTS) : max_slots;

  logic [SLOT_W-1:0] cur_s;
  assign cur_s = (current_slot >= SLOT_W'(NUM_SLOTS)) ? '0 : current_slot;

  function automatic logic is_active(input logic [31:0] id);
    return id != 32'd0 && id != ID_ENDED;
  endfunction
  function automatic logic is_downish(input action_t a);
    return a == ACT_DOWN || a == ACT_PDOWN;
  endfunction
  function automatic logic is_upish(input action_t a);
    return a == ACT_UP || a == ACT_PUP;
  endfunction

  logic accept_in;
  assign in_ready  = (state == ST_IDLE);
  assign accept_in = in_valid && in_ready;

  logic is_sync, is_abs_live;
  assign is_sync = ev_type == TYPE_SYN && ev_code == 16'd0 && ev_value == 32'sd0;
  assign is_abs_live = ev_type == TYPE_ABS && eff_slots != '0;

  // restoring divide step
  logic [CAL_W:0] trial;
  logic [CAL_W:0] shifted;
  assign shifted = {rem_r[CAL_W-1:0], rem_q[PROD_W-1]};
  assign trial = shifted - {1'b0, divisor};

  logic walk_active;
  logic walk_end;
  assign walk_active = is_active(slot_id[walk]);
  assign walk_end = (walk + 1'b1) >= eff_slots;

  logic out_free;
  assign out_free = !out_valid || out_ready;

  logic emit_now;
  assign emit_now = state == ST_EMIT && out_free && (total == '0 || walk_active);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          if (is_sync) begin
            state_next = ST_SCAN;
          end else if (is_abs_live && (ev_code == CODE_POS_X || ev_code == CODE_POS_Y)
                       && !ev_value[31]) begin
            state_next = ST_MULT;
          end
        end
      end
      ST_MULT: state_next = ST_DIV;
      ST_DIV:  if (bit_cnt == 6'(PROD_W - 1)) state_next = ST_IDLE;
      ST_SCAN: begin
        if (eff_slots == '0 || walk_end) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (total == '0) state_next = ST_WAIT;
          else if (walk_active && emitted + 1'b1 == total) state_next = ST_WAIT;
        end
      end
      ST_WAIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots <= '0;
      resolution_x <= 16'd1;
      resolution_y <= 16'd1;
      calibrated_width <= CAL_W'(1);
      calibrated_height <= CAL_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_SLOTS: max_slots <= cfg_data[3:0];
        REG_RES_X:     resolution_x <= cfg_data[15:0];
        REG_RES_Y:     resolution_y <= cfg_data[15:0];
        REG_CAL_W:     calibrated_width <= cfg_data;
        REG_CAL_H:     calibrated_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_id[i] <= '0;
        slot_action[i] <= ACT_DOWN;
        slot_x[i] <= '0;
        slot_y[i] <= '0;
        prev_id_nonzero[i] <= 1'b0;
        prev_action[i] <= ACT_DOWN;
      end
      touch_count <= '0;
      current_slot <= '0;
      overall_action <= ACT_DOWN;
      first_touch_time <= '0;
      latest_time <= '0;
      walk <= '0;
      total <= '0;
      emitted <= '0;
      bit_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit_now) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          walk <= '0;
          total <= '0;
          emitted <= '0;
          if (accept_in && is_abs_live) begin
            latest_time <= stamp_us;
            div_slot <= cur_s;
            div_is_y <= ev_code == CODE_POS_Y;
            raw_val <= ev_value;
            mul_res <= (ev_code == CODE_POS_Y) ? resolution_y : resolution_x;
            divisor <= (ev_code == CODE_POS_Y)
                       ? ((calibrated_height == '0) ? CAL_W'(1) : calibrated_height)
                       : ((calibrated_width == '0) ? CAL_W'(1) : calibrated_width);
            case (ev_code)
              CODE_SLOT: begin
                if (!ev_value[31] && ev_value[30:0] < 31'(eff_slots))
                  current_slot <= ev_value[SLOT_W-1:0];
              end
              CODE_TRACK: begin
                if (ev_value == ID_ENDED) begin
                  if (touch_count != '0) begin
                    touch_count <= touch_count - 1'b1;
                    if (touch_count == COUNT_W'(1)) begin
                      slot_action[cur_s] <= ACT_UP;
                      overall_action <= ACT_UP;
                    end else begin
                      slot_action[cur_s] <= ACT_PUP;
                    end
                  end
                end else begin
                  if (touch_count == '0) begin
                    slot_action[cur_s] <= ACT_DOWN;
                    overall_action <= ACT_DOWN;
                    first_touch_time <= stamp_us;
                  end else begin
                    slot_action[cur_s] <= ACT_PDOWN;
                  end
                  slot_id[cur_s] <= ev_value;
                  // clamp to slot count, then count this touch
                  if (touch_count > eff_slots) touch_count <= eff_slots + 1'b1;
                  else if (touch_count != COUNT_SAT) touch_count <= touch_count + 1'b1;
                end
              end
              CODE_POS_X, CODE_POS_Y: begin
                if (ev_value[31]) begin
                  if (ev_code == CODE_POS_Y) slot_y[cur_s] <= '0;
                  else slot_x[cur_s] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MULT: begin
          rem_q <= PROD_W'({48'(raw_val) * 48'(mul_res), {COORD_FRAC_BITS{1'b0}}});
          rem_r <= '0;
          bit_cnt <= '0;
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (!trial[CAL_W]) begin
            rem_r <= trial;
            rem_q <= {rem_q[PROD_W-2:0], 1'b1};
          end else begin
            rem_r <= shifted;
            rem_q <= {rem_q[PROD_W-2:0], 1'b0};
          end
          if (bit_cnt == 6'(PROD_W - 1)) begin
            // final quotient = shifted rem_q with the new bit
            if (rem_q[PROD_W-2:COORD_W-1] != '0) begin
              if (div_is_y) slot_y[div_slot] <= COORD_MAX;
              else slot_x[div_slot] <= COORD_MAX;
            end else begin
              if (div_is_y) slot_y[div_slot] <= {rem_q[COORD_W-2:0], !trial[CAL_W]};
              else slot_x[div_slot] <= {rem_q[COORD_W-2:0], !trial[CAL_W]};
            end
          end
        end
        ST_SCAN: begin
          if (eff_slots != '0) begin
            if (walk_active) begin
              total <= total + 1'b1;
              if (prev_id_nonzero[walk] && is_downish(prev_action[walk])
                  && is_downish(slot_action[walk])) begin
                slot_action[walk] <= ACT_MOVE;
                overall_action <= ACT_MOVE;
              end
            end
            walk <= walk_end ? '0 : walk + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (total == '0) begin
              out_valid <= 1'b1;
              slot_index <= '0;
              tracking_id <= '0;
              pointer_action <= '0;
              pos_x <= '0;
              pos_y <= '0;
              pointer_valid <= 1'b0;
              last <= 1'b1;
              pointer_count <= '0;
              sequence_error <= 1'b0;
              gesture_action <= overall_action;
              down_time_us <= first_touch_time;
              event_time_us <= latest_time;
            end else begin
              if (walk_active) begin
                out_valid <= 1'b1;
                slot_index <= walk;
                tracking_id <= slot_id[walk];
                pointer_action <= slot_action[walk];
                pos_x <= slot_x[walk];
                pos_y <= slot_y[walk];
                pointer_valid <= 1'b1;
                last <= emitted + 1'b1 == total;
                pointer_count <= total;
                sequence_error <= is_upish(slot_action[walk]) && is_upish(prev_action[walk]);
                gesture_action <= overall_action;
                down_time_us <= first_touch_time;
                event_time_us <= latest_time;
                emitted <= emitted + 1'b1;
                if (is_upish(slot_action[walk])) slot_id[walk] <= ID_ENDED;
              end
              walk <= walk + 1'b1;
            end
          end
        end
        ST_WAIT: begin
          // snapshot for the next report
          if (out_free) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (SLOT_W'(i) < eff_slots) begin
                prev_id_nonzero[i] <= slot_id[i] != 32'd0;
                prev_action[i] <= slot_action[i];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |-> pointer_count == emitted)
    else $error("record count mismatch on last");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && pointer_valid |-> pointer_count != '0 && slot_index < SLOT_W'(NUM_SLOTS))
    else $error("bad valid record");
  assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !in_ready)
    else $error("ready during divide");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !pointer_valid |-> last && pointer_count == '0)
    else $error("empty report malformed");

endmodule
